// ----- hdl/rbffa_pkg.sv -----
`timescale 1ns / 1ps

package rbffa_pkg;

  // Field widths of the request, result and register transactions
  localparam int PIX_W = 11;
  localparam int POS_W = 10;
  localparam int CNT_W = 13;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Page size after reset, in pixels on each axis
  localparam int PAGE_RST_PIX = 1024;

  // Request opcodes
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_CLEAR = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic REG_PAGE_WIDTH  = 1'b0;
  localparam logic REG_PAGE_HEIGHT = 1'b1;

endpackage

// ----- hdl/rbffa_ram.sv -----
`timescale 1ns / 1ps

module rbffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/rect_block_first_fit_allocator_top.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+-------------------------------------------
// request   | in        | in_valid_i / in_ready_o | opcode_i, req_width_i, req_height_i
// result    | out       | out_valid_o/out_ready_i | granted_o, pos_x_o, pos_y_o, blocks_free_o
// register  | in        | psel/penable/pready     | pwrite, paddr, pwdata, prdata
//
// A clear goes straight to its result; an allocate refused on its size or the free
//   count, or an empty one, is answered after the check. A searched allocate ORs the hn
//   rows under each tried top row, narrows the free columns, and marks hn rows when granted; hn
//   and wn are the rectangle in blocks; the occupancy RAM's single read port sets the row loop.
// Reset: the occupancy rows carry one valid flag each, so reset, a clear transaction
//   and a register write empty the page by dropping the flags; no clearing pass.
// Stalls: one request is in work at a time; the next is taken while a result waits
//   in the output register.

module rect_block_first_fit_allocator_top #(
  parameter int MAX_BLOCKS_X = 64,
  parameter int MAX_BLOCKS_Y = 64,
  parameter int BLOCK_SHIFT  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbffa_pkg::APB_AW-1:0]  paddr,
  input  logic [rbffa_pkg::APB_DW-1:0]  pwdata,
  output logic [rbffa_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  // request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [rbffa_pkg::PIX_W-1:0]   req_width_i,
  input  logic [rbffa_pkg::PIX_W-1:0]   req_height_i,
  // result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          granted_o,
  output logic [rbffa_pkg::POS_W-1:0]   pos_x_o,
  output logic [rbffa_pkg::POS_W-1:0]   pos_y_o,
  output logic [rbffa_pkg::CNT_W-1:0]   blocks_free_o
);

  import rbffa_pkg::*;

  // Widths derived from the page limits
  localparam int BX_W   = $clog2(MAX_BLOCKS_X + 1);
  localparam int BY_W   = $clog2(MAX_BLOCKS_Y + 1);
  localparam int XI_W   = (MAX_BLOCKS_X > 1) ? $clog2(MAX_BLOCKS_X) : 1;
  localparam int YI_W   = (MAX_BLOCKS_Y > 1) ? $clog2(MAX_BLOCKS_Y) : 1;
  localparam int FREE_W = $clog2(MAX_BLOCKS_X * MAX_BLOCKS_Y + 1);
  localparam int REQ_W  = PIX_W + 1 - BLOCK_SHIFT;
  localparam logic [PIX_W-1:0] BLK_MASK = PIX_W'((1 << BLOCK_SHIFT) - 1);

  // Page in blocks after reset, saturated at the limits
  localparam int RST_BLK = (PAGE_RST_PIX + (1 << BLOCK_SHIFT) - 1) >> BLOCK_SHIFT;
  localparam int RST_BX  = (RST_BLK > MAX_BLOCKS_X) ? MAX_BLOCKS_X : RST_BLK;
  localparam int RST_BY  = (RST_BLK > MAX_BLOCKS_Y) ? MAX_BLOCKS_Y : RST_BLK;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_SHRINK = 3'd3;
  localparam logic [2:0] ST_MARK   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  // Round pixels up to whole blocks, then saturate at lim
  function automatic int to_blocks(input logic [PIX_W-1:0] pix, input int lim);
    int n;
    n = int'(pix >> BLOCK_SHIFT) + ((|(pix & BLK_MASK)) ? 1 : 0);
    return (n > lim) ? lim : n;
  endfunction

  logic [2:0]              state_q, state_d;
  logic [PIX_W-1:0]        pw_q, pw_d, ph_q, ph_d;
  logic [BX_W-1:0]         bx_q, bx_d;
  logic [BY_W-1:0]         by_q, by_d;
  logic                    reload_q, reload_d;
  logic [FREE_W-1:0]       free_q, free_d;
  logic [MAX_BLOCKS_Y-1:0] row_valid_q, row_valid_d;
  logic [REQ_W-1:0]        wn_q, wn_d, hn_q, hn_d;
  logic [FREE_W-1:0]       area_q, area_d;
  logic [YI_W-1:0]         row_i_q, row_i_d;
  logic [BY_W-1:0]         k_q, k_d;
  logic                    pend_q, pend_d;
  logic                    rvld_q, rvld_d;
  logic [YI_W-1:0]         wr_addr_q, wr_addr_d;
  logic [MAX_BLOCKS_X-1:0] acc_q, acc_d;
  logic [MAX_BLOCKS_X-1:0] fits_q, fits_d;
  logic [BX_W-1:0]         sh_cnt_q, sh_cnt_d;
  logic [MAX_BLOCKS_X-1:0] mask_q, mask_d;
  logic                    res_granted_q, res_granted_d;
  logic [POS_W-1:0]        res_x_q, res_x_d, res_y_q, res_y_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_granted_q, out_granted_d;
  logic [POS_W-1:0]        out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CNT_W-1:0]        out_free_q, out_free_d;

  logic                    cfg_wr;
  logic [BX_W-1:0]         wb;
  logic [BY_W-1:0]         hb;
  logic [FREE_W-1:0]       full_cnt;
  logic                    rd_en;
  logic [YI_W-1:0]         rd_addr;
  logic [MAX_BLOCKS_X-1:0] ram_rdata;
  logic [MAX_BLOCKS_X-1:0] row_data;
  logic [MAX_BLOCKS_X-1:0] acc_next;
  logic [MAX_BLOCKS_X-1:0] limit;
  logic [MAX_BLOCKS_X-1:0] span_mask;
  logic [XI_W-1:0]         first_idx;
  logic                    ram_we;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_ready_o = (state_q == ST_IDLE);

  assign wb       = BX_W'(wn_q);
  assign hb       = BY_W'(hn_q);
  assign full_cnt = FREE_W'(32'(bx_q) * 32'(by_q));
  assign rd_addr  = YI_W'(32'(row_i_q) + 32'(k_q));
  assign rd_en    = (state_q inside {ST_SCAN, ST_MARK}) && (k_q < hb);
  // A row never written since the last clear reads as all free
  assign row_data = rvld_q ? ram_rdata : '0;
  assign acc_next = pend_q ? (acc_q | row_data) : acc_q;
  assign ram_we   = (state_q == ST_MARK) && pend_q;

  // Register read back
  always_comb begin
    case (paddr[2])
      REG_PAGE_WIDTH:  prdata = APB_DW'(pw_q);
      REG_PAGE_HEIGHT: prdata = APB_DW'(ph_q);
      default:         prdata = '0;
    endcase
  end

  // Columns inside the page, lowest fitting column, and the span to mark
  always_comb begin
    limit     = '0;
    span_mask = '0;
    first_idx = '0;
    for (int b = 0; b < MAX_BLOCKS_X; b++) begin
      limit[b] = (b < int'(bx_q));
    end
    for (int b = MAX_BLOCKS_X - 1; b >= 0; b--) begin
      if (fits_q[b]) begin
        first_idx = XI_W'(b);
      end
    end
    for (int b = 0; b < MAX_BLOCKS_X; b++) begin
      span_mask[b] = (b >= int'(first_idx)) && (b < int'(first_idx) + int'(wb));
    end
  end

  always_comb begin
    state_d       = state_q;
    pw_d          = pw_q;
    ph_d          = ph_q;
    bx_d          = bx_q;
    by_d          = by_q;
    reload_d      = 1'b0;
    free_d        = free_q;
    row_valid_d   = row_valid_q;
    wn_d          = wn_q;
    hn_d          = hn_q;
    area_d        = area_q;
    row_i_d       = row_i_q;
    k_d           = k_q;
    pend_d        = rd_en;
    rvld_d        = rd_en && row_valid_q[rd_addr];
    wr_addr_d     = rd_addr;
    acc_d         = acc_q;
    fits_d        = fits_q;
    sh_cnt_d      = sh_cnt_q;
    mask_d        = mask_q;
    res_granted_d = res_granted_q;
    res_x_d       = res_x_q;
    res_y_d       = res_y_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_granted_d = out_granted_q;
    out_x_d       = out_x_q;
    out_y_d       = out_y_q;
    out_free_d    = out_free_q;

    // Refill the free count in the cycle after a page register write
    if (reload_q) begin
      free_d = full_cnt;
    end

    // A page register write re-initialises the page
    if (cfg_wr) begin
      case (paddr[2])
        REG_PAGE_WIDTH: begin
          pw_d = pwdata[PIX_W-1:0];
          bx_d = BX_W'(to_blocks(pwdata[PIX_W-1:0], MAX_BLOCKS_X));
        end
        REG_PAGE_HEIGHT: begin
          ph_d = pwdata[PIX_W-1:0];
          by_d = BY_W'(to_blocks(pwdata[PIX_W-1:0], MAX_BLOCKS_Y));
        end
        default: ;
      endcase
      row_valid_d = '0;
      reload_d    = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OPC_CLEAR) begin
            row_valid_d   = '0;
            free_d        = full_cnt;
            res_granted_d = 1'b1;
            res_x_d       = '0;
            res_y_d       = '0;
            state_d       = ST_RESP;
          end else begin
            wn_d    = REQ_W'(to_blocks(req_width_i, 32'hFFFF));
            hn_d    = REQ_W'(to_blocks(req_height_i, 32'hFFFF));
            state_d = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        res_granted_d = 1'b0;
        res_x_d       = '0;
        res_y_d       = '0;
        if ((free_q == '0) || (32'(wn_q) > 32'(bx_q)) || (32'(hn_q) > 32'(by_q))) begin
          state_d = ST_RESP;
        end else if ((wn_q == '0) || (hn_q == '0)) begin
          // Empty rectangle: grant at the origin, take no blocks
          res_granted_d = 1'b1;
          state_d       = ST_RESP;
        end else begin
          row_i_d = '0;
          k_d     = '0;
          acc_d   = '0;
          area_d  = FREE_W'(32'(wb) * 32'(hb));
          state_d = ST_SCAN;
        end
      end

      // OR together the hn rows under the candidate top row
      ST_SCAN: begin
        if (rd_en) begin
          k_d = k_q + BY_W'(1);
        end
        acc_d = acc_next;
        if (!rd_en && pend_q) begin
          fits_d   = ~acc_next & limit;
          sh_cnt_d = wb - BX_W'(1);
          state_d  = ST_SHRINK;
        end
      end

      // Narrow the free columns to starts of wn-wide free runs
      ST_SHRINK: begin
        if (sh_cnt_q != '0) begin
          fits_d   = fits_q & (fits_q >> 1);
          sh_cnt_d = sh_cnt_q - BX_W'(1);
        end else if (|fits_q) begin
          res_granted_d = 1'b1;
          res_x_d       = POS_W'(32'(first_idx) << BLOCK_SHIFT);
          res_y_d       = POS_W'(32'(row_i_q) << BLOCK_SHIFT);
          mask_d        = span_mask;
          k_d           = '0;
          state_d       = ST_MARK;
        end else if (32'(row_i_q) + 32'd1 + 32'(hb) > 32'(by_q)) begin
          state_d = ST_RESP;
        end else begin
          row_i_d = row_i_q + YI_W'(1);
          k_d     = '0;
          acc_d   = '0;
          state_d = ST_SCAN;
        end
      end

      // Read, set the span, write back; the next row is read while the last is written back
      ST_MARK: begin
        if (rd_en) begin
          k_d = k_q + BY_W'(1);
        end
        if (pend_q) begin
          row_valid_d[wr_addr_q] = 1'b1;
        end
        if (!rd_en && pend_q) begin
          free_d  = free_q - area_q;
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_granted_d = res_granted_q;
          out_x_d       = res_x_q;
          out_y_d       = res_y_q;
          out_free_d    = CNT_W'(32'(free_q));
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pw_q          <= PIX_W'(PAGE_RST_PIX);
      ph_q          <= PIX_W'(PAGE_RST_PIX);
      bx_q          <= BX_W'(RST_BX);
      by_q          <= BY_W'(RST_BY);
      reload_q      <= 1'b0;
      free_q        <= FREE_W'(RST_BX * RST_BY);
      row_valid_q   <= '0;
      wn_q          <= '0;
      hn_q          <= '0;
      area_q        <= '0;
      row_i_q       <= '0;
      k_q           <= '0;
      pend_q        <= 1'b0;
      rvld_q        <= 1'b0;
      wr_addr_q     <= '0;
      acc_q         <= '0;
      fits_q        <= '0;
      sh_cnt_q      <= '0;
      mask_q        <= '0;
      res_granted_q <= 1'b0;
      res_x_q       <= '0;
      res_y_q       <= '0;
      out_valid_q   <= 1'b0;
      out_granted_q <= 1'b0;
      out_x_q       <= '0;
      out_y_q       <= '0;
      out_free_q    <= '0;
    end else begin
      state_q       <= state_d;
      pw_q          <= pw_d;
      ph_q          <= ph_d;
      bx_q          <= bx_d;
      by_q          <= by_d;
      reload_q      <= reload_d;
      free_q        <= free_d;
      row_valid_q   <= row_valid_d;
      wn_q          <= wn_d;
      hn_q          <= hn_d;
      area_q        <= area_d;
      row_i_q       <= row_i_d;
      k_q           <= k_d;
      pend_q        <= pend_d;
      rvld_q        <= rvld_d;
      wr_addr_q     <= wr_addr_d;
      acc_q         <= acc_d;
      fits_q        <= fits_d;
      sh_cnt_q      <= sh_cnt_d;
      mask_q        <= mask_d;
      res_granted_q <= res_granted_d;
      res_x_q       <= res_x_d;
      res_y_q       <= res_y_d;
      out_valid_q   <= out_valid_d;
      out_granted_q <= out_granted_d;
      out_x_q       <= out_x_d;
      out_y_q       <= out_y_d;
      out_free_q    <= out_free_d;
    end
  end

  // Occupancy rows: one bit per block, one row per word
  rbffa_ram #(
    .WIDTH (MAX_BLOCKS_X),
    .DEPTH (MAX_BLOCKS_Y)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr_q),
    .wdata_i (row_data | mask_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign granted_o     = out_granted_q;
  assign pos_x_o       = out_x_q;
  assign pos_y_o       = out_y_q;
  assign blocks_free_o = out_free_q;

  // Row reads stay inside the page
  a_read_in_page : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(rd_addr) < 32'(by_q)))
    else $error("occupancy read beyond page height");

  // Candidate columns never reach past the page width
  a_fits_in_page : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHRINK) |-> ((fits_q & ~limit) == '0))
    else $error("candidate column beyond page width");

  // Marking only starts with enough free blocks to cover the rectangle
  a_area_covered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MARK) && !reload_q) |-> (area_q <= free_q))
    else $error("rectangle area exceeds free count");

  // A refused request reports the origin
  a_refused_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> ((pos_x_o == '0) && (pos_y_o == '0)))
    else $error("refused request with non-zero position");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rbffa_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int BLOCKS_X_MAX  = 64;
  localparam int BLOCKS_Y_MAX  = 64;
  localparam int BLOCK_SH      = 4;
  // Sized from the slowest legal allocate, which tries up to 64 top rows.
  // Allow for ~700 of those with both sides stalling, then triple it.
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    logic             granted;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [CNT_W-1:0] blocks_free;
  } alloc_result_t;

  // One row of the directed table. Where 'known' is set, the result is typed in
  // by hand. Otherwise the page copy supplies it.
  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] h;
    logic             known;
    alloc_result_t    res;
  } directed_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              opcode_i = OPC_ALLOC;
  logic [PIX_W-1:0]  req_width_i = '0;
  logic [PIX_W-1:0]  req_height_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              granted_o;
  logic [POS_W-1:0]  pos_x_o;
  logic [POS_W-1:0]  pos_y_o;
  logic [CNT_W-1:0]  blocks_free_o;

  // Software copy of the page
  logic [BLOCKS_X_MAX-1:0] occupancy [BLOCKS_Y_MAX];
  logic [PIX_W-1:0]        page_w = PIX_W'(PAGE_RST_PIX);
  logic [PIX_W-1:0]        page_h = PIX_W'(PAGE_RST_PIX);
  int                      cols;
  int                      rows;
  int                      free_blocks;

  alloc_result_t awaited_results [$];
  alloc_result_t result_due;
  int            error_count = 0;
  int            cycle_count = 0;
  bit            idling_on = 1'b1;
  bit            long_hold_req = 1'b0;

  // Requests on the reset page (64 x 64 blocks, 4096 free)
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // zero-size request on an empty page: granted at the origin, nothing taken
    '{OPC_ALLOC, 11'd0,    11'd0,    1'b1, '{1'b1, 10'd0, 10'd0, 13'd4096}},
    // whole page in one go
    '{OPC_ALLOC, 11'd1024, 11'd1024, 1'b1, '{1'b1, 10'd0, 10'd0, 13'd0}},
    // page full: even a zero-size request fails
    '{OPC_ALLOC, 11'd0,    11'd0,    1'b1, '{1'b0, 10'd0, 10'd0, 13'd0}},
    '{OPC_ALLOC, 11'd16,   11'd16,   1'b1, '{1'b0, 10'd0, 10'd0, 13'd0}},
    // clear ignores its payload
    '{OPC_CLEAR, 11'd2047, 11'd2047, 1'b1, '{1'b1, 10'd0, 10'd0, 13'd4096}},
    // one block too wide, far too tall, both at their maximum
    '{OPC_ALLOC, 11'd1025, 11'd16,   1'b1, '{1'b0, 10'd0, 10'd0, 13'd4096}},
    '{OPC_ALLOC, 11'd16,   11'd2047, 1'b1, '{1'b0, 10'd0, 10'd0, 13'd4096}},
    '{OPC_ALLOC, 11'd2047, 11'd2047, 1'b1, '{1'b0, 10'd0, 10'd0, 13'd4096}},
    // a single pixel still takes a whole block
    '{OPC_ALLOC, 11'd1,    11'd1,    1'b1, '{1'b1, 10'd0, 10'd0, 13'd4095}},
    '{OPC_ALLOC, 11'd17,   11'd15,   1'b0, '0},
    '{OPC_ALLOC, 11'd1008, 11'd16,   1'b0, '0},
    '{OPC_ALLOC, 11'd1024, 11'd1008, 1'b0, '0},
    '{OPC_ALLOC, 11'd1024, 11'd992,  1'b0, '0},
    '{OPC_ALLOC, 11'd16,   11'd16,   1'b0, '0},
    '{OPC_ALLOC, 11'd0,    11'd1024, 1'b0, '0},
    '{OPC_CLEAR, 11'd0,    11'd0,    1'b1, '{1'b1, 10'd0, 10'd0, 13'd4096}},
    '{OPC_ALLOC, 11'd1023, 11'd1023, 1'b1, '{1'b1, 10'd0, 10'd0, 13'd0}},
    '{OPC_CLEAR, 11'd1024, 11'd0,    1'b1, '{1'b1, 10'd0, 10'd0, 13'd4096}},
    '{OPC_ALLOC, 11'd512,  11'd512,  1'b0, '0},
    '{OPC_ALLOC, 11'd513,  11'd512,  1'b0, '0}
  };

  rect_block_first_fit_allocator_top #(
    .MAX_BLOCKS_X(BLOCKS_X_MAX),
    .MAX_BLOCKS_Y(BLOCKS_Y_MAX),
    .BLOCK_SHIFT (BLOCK_SH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .req_width_i  (req_width_i),
    .req_height_i (req_height_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .granted_o    (granted_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .blocks_free_o(blocks_free_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Pixels to whole blocks, rounded up and saturated at 'limit'
  function automatic int blocks_of(input logic [PIX_W-1:0] pixels, input int limit);
    int n;
    n = int'(pixels >> BLOCK_SH) + int'(pixels[BLOCK_SH-1:0] != '0);
    return n > limit ? limit : n;
  endfunction

  // Empty the page and size it from the current registers
  function automatic void clear_page();
    foreach (occupancy[r]) occupancy[r] = '0;
    cols        = blocks_of(page_w, BLOCKS_X_MAX);
    rows        = blocks_of(page_h, BLOCKS_Y_MAX);
    free_blocks = cols * rows;
  endfunction

  // Apply one request to the page copy and return what the block should answer
  function automatic alloc_result_t predict_allocation(input logic op,
                                                       input logic [PIX_W-1:0] w,
                                                       input logic [PIX_W-1:0] h);
    alloc_result_t           res;
    int                      wn;
    int                      hn;
    int                      i;
    int                      j;
    int                      k;
    logic [BLOCKS_X_MAX:0]   span;
    logic [BLOCKS_X_MAX-1:0] mask;
    bit                      fits;
    res = '0;
    if (op == OPC_CLEAR) begin
      clear_page();
      res.granted = 1'b1;
    end else if (free_blocks != 0) begin
      wn = blocks_of(w, 65535);
      hn = blocks_of(h, 65535);
      if (wn <= cols && hn <= rows) begin
        // wn ones at the bottom; the spare top bit lets a width of 64 give all ones
        span = ({{BLOCKS_X_MAX{1'b0}}, 1'b1} << wn) - 1'b1;
        // raster order: top row outer, left column inner
        for (i = 0; i + hn <= rows && !res.granted; i++) begin
          for (j = 0; j + wn <= cols && !res.granted; j++) begin
            mask = span[BLOCKS_X_MAX-1:0] << j;
            fits = 1'b1;
            for (k = 0; k < hn; k++)
              if ((occupancy[i+k] & mask) != '0) fits = 1'b0;
            if (fits) begin
              for (k = 0; k < hn; k++) occupancy[i+k] |= mask;
              free_blocks -= wn * hn;
              res.granted = 1'b1;
              res.pos_x   = POS_W'(j << BLOCK_SH);
              res.pos_y   = POS_W'(i << BLOCK_SH);
            end
          end
        end
      end
    end
    res.blocks_free = CNT_W'(free_blocks);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Write one page register, mirror it in the copy, then read it back.
  // Call at a falling edge while the block is idle; returns at a falling edge.
  task automatic write_register(input logic idx, input logic [PIX_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_PAGE_WIDTH) page_w = value;
    else page_h = value;
    clear_page();
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", APB_DW'(value), prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one request and hold it until the block takes it. Called and
  // returns at a falling edge; valid stays high so that back-to-back
  // transactions follow without a gap.
  task automatic send_request(input logic op, input logic [PIX_W-1:0] w,
                              input logic [PIX_W-1:0] h, input logic known,
                              input alloc_result_t known_res);
    alloc_result_t res;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    req_width_i  <= w;
    req_height_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    // the page copy advances even where the answer is typed in
    res = predict_allocation(op, w, h);
    if (known) res = known_res;
    awaited_results = {awaited_results, res};
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every awaited result; returns at a falling edge
  task automatic drain();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Pick a random request. Most are rectangles that fit comfortably on the
  // current page, so the page fills up over a sequence of allocations. A clear
  // comes now and then to start over. The rest are raw 11-bit sizes,
  // zero-size requests and whole-page requests.
  task automatic pick_request(output logic op, output logic [PIX_W-1:0] w,
                              output logic [PIX_W-1:0] h);
    int mode;
    int span_x;
    int span_y;
    mode   = $urandom_range(0, 19);
    span_x = cols > 3 ? cols / 3 : 1;
    span_y = rows > 3 ? rows / 3 : 1;
    op     = OPC_ALLOC;
    w      = PIX_W'((($urandom_range(1, span_x) - 1) << BLOCK_SH) + $urandom_range(1, 16));
    h      = PIX_W'((($urandom_range(1, span_y) - 1) << BLOCK_SH) + $urandom_range(1, 16));
    case (mode)
      0, 1: begin
        op = OPC_CLEAR;
        w  = PIX_W'($urandom_range(0, 2047));
        h  = PIX_W'($urandom_range(0, 2047));
      end
      2, 3: begin
        w = PIX_W'($urandom_range(0, 2047));
        h = PIX_W'($urandom_range(0, 2047));
      end
      4: begin
        if ($urandom_range(0, 1) == 0) w = '0;
        else h = '0;
      end
      5: begin
        w = page_w;
        h = page_h;
      end
      default: ;
    endcase
  endtask

  // Reprogram the page, which also empties it, then run random requests
  task automatic run_phase(input logic [PIX_W-1:0] pw, input logic [PIX_W-1:0] ph,
                           input int count);
    logic             op;
    logic [PIX_W-1:0] w;
    logic [PIX_W-1:0] h;
    write_register(REG_PAGE_WIDTH, pw);
    write_register(REG_PAGE_HEIGHT, ph);
    repeat (count) begin
      pick_request(op, w, h);
      send_request(op, w, h, 1'b0, '0);
    end
    drain();
  endtask

  // Result side: stall in short random bursts, plus one long hold-off when
  // asked, counted here so the sender keeps offering meanwhile.
  always begin
    @(negedge clk_i);
    if (long_hold_req) begin
      out_ready_i <= 1'b0;
      repeat (LONG_HOLD) @(negedge clk_i);
      long_hold_req = 1'b0;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  // Result check: sample at the rising edge, compare with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual granted %0d pos %0d,%0d free %0d",
                 $time, granted_o, pos_x_o, pos_y_o, blocks_free_o);
        error_count++;
      end else begin
        result_due = awaited_results.pop_front();
        check_field("granted", 32'(result_due.granted), 32'(granted_o));
        check_field("pos_x", 32'(result_due.pos_x), 32'(pos_x_o));
        check_field("pos_y", 32'(result_due.pos_y), 32'(pos_y_o));
        check_field("blocks_free", 32'(result_due.blocks_free), 32'(blocks_free_o));
      end
    end
  end

  // Watchdog: end the run if the block hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clear_page();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // hand-picked requests on the reset page
    foreach (directed_rows[n])
      send_request(directed_rows[n].op, directed_rows[n].w, directed_rows[n].h,
                   directed_rows[n].known, directed_rows[n].res);
    drain();

    // page sizes: default, one block, zero along either axis, odd sizes,
    // saturating, tall and narrow, wide and shallow
    run_phase(11'd1024, 11'd1024, 50);
    run_phase(11'd16, 11'd16, 40);
    run_phase(11'd0, 11'd700, 20);
    run_phase(11'd700, 11'd0, 20);
    run_phase(11'd100, 11'd50, 70);
    run_phase(11'd2047, 11'd2047, 50);
    // small page, fast requests: let the block back up against a stalled result
    long_hold_req = 1'b1;
    run_phase(11'd64, 11'd64, 60);
    run_phase(11'd256, 11'd1024, 60);
    run_phase(11'd1024, 11'd48, 60);
    run_phase(11'd200, 11'd300, 70);
    run_phase(11'd33, 11'd1000, 60);
    // run the tail at full rate on both sides
    idling_on = 1'b0;
    run_phase(11'd500, 11'd400, 60);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
